>>> hdl/rqz_pkg.sv
package rqz_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SCALE      = 2'd0;
   localparam logic [1:0] CSR_OFFSET     = 2'd1;
   localparam logic [1:0] CSR_CLAMP_LOW  = 2'd2;
   localparam logic [1:0] CSR_CLAMP_HIGH = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 30;

   // scale field layout
   localparam int MANT_W  = 23;
   localparam int EXP_W   = 7;
   localparam int SHIFT_W = 5;

   // shift = 126 - exponent, saturated to 0..31
   localparam logic [EXP_W-1:0]   SHIFT_BASE   = 7'd126;
   localparam logic [EXP_W-1:0]   EXP_MAX      = 7'd127;
   localparam logic [EXP_W-1:0]   EXP_MIN_FULL = 7'd95;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX    = 5'd31;

   // reset values (scale 0.5)
   localparam logic [MANT_W-1:0]  MANT_RESET  = 23'h0;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd0;
   localparam logic [7:0]         ZP_RESET    = 8'd0;
   localparam logic [7:0]         CLAMP_LOW_RESET  = 8'd0;
   localparam logic [7:0]         CLAMP_HIGH_RESET = 8'd255;

   typedef struct packed {
      logic signed [31:0] accumulator;
      logic               last_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] quantized;
      logic       last_out;
   } rsp_payload_type;

   // derived configuration seen by the datapath
   typedef struct packed {
      logic [MANT_W-1:0]  mant;
      logic [SHIFT_W-1:0] shift;
      logic [7:0]         offset;
      logic [7:0]         clamp_low;
      logic [7:0]         clamp_high;
   } cfg_type;

endpackage

>>> hdl/rqz_csr.sv
module rqz_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [rqz_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rqz_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output rqz_pkg::cfg_type                    cfg
);
   import rqz_pkg::*;

   logic [MANT_W-1:0]  mant_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   logic [7:0]         offset_ff;
   logic [7:0]         clamp_low_ff;
   logic [7:0]         clamp_high_ff;
   logic [EXP_W-1:0]   wr_exp;
   logic [EXP_W-1:0]   shift_raw;

   // shift is worked out once at write time
   assign wr_exp    = csr_wdata[MANT_W +: EXP_W];
   assign shift_raw = SHIFT_BASE - wr_exp;

   always_comb begin
      if (wr_exp == EXP_MAX) begin
         shift_in = '0;
      end else if (wr_exp < EXP_MIN_FULL) begin
         shift_in = SHIFT_MAX;
      end else begin
         shift_in = shift_raw[SHIFT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mant_ff       <= MANT_RESET;
         shift_ff      <= SHIFT_RESET;
         offset_ff     <= ZP_RESET;
         clamp_low_ff  <= CLAMP_LOW_RESET;
         clamp_high_ff <= CLAMP_HIGH_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCALE: begin
               mant_ff  <= csr_wdata[MANT_W-1:0];
               shift_ff <= shift_in;
            end
            CSR_OFFSET:     offset_ff     <= csr_wdata[7:0];
            CSR_CLAMP_LOW:  clamp_low_ff  <= csr_wdata[7:0];
            CSR_CLAMP_HIGH: clamp_high_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.mant       = mant_ff;
   assign cfg.shift      = shift_ff;
   assign cfg.offset     = offset_ff;
   assign cfg.clamp_low  = clamp_low_ff;
   assign cfg.clamp_high = clamp_high_ff;

endmodule

>>> hdl/rqz_datapath.sv
module rqz_datapath (
   input  rqz_pkg::cfg_type   cfg,
   input  logic signed [31:0] accumulator,
   output logic [7:0]         quantized
);
   import rqz_pkg::*;

   logic signed [24:0] mult_s;
   logic signed [56:0] prod;
   logic signed [56:0] prod_rnd;
   logic signed [31:0] q;
   logic [31:0]        mask;
   logic [31:0]        low_bits;
   logic signed [32:0] rem;
   logic signed [32:0] thr;
   logic               round_up;
   logic signed [31:0] q_shr;
   logic signed [32:0] sh;
   logic signed [16:0] sat16;
   logic signed [17:0] with_zp;
   logic [7:0]         u8;
   logic [7:0]         upper_clamped;

   // q31 multiply: multiplier is {1, mant} << 7, the << 7 folds into the bit pick
   assign mult_s   = $signed({2'b01, cfg.mant});
   assign prod     = accumulator * mult_s;
   assign prod_rnd = prod + 57'sh0800000;
   assign q        = prod_rnd[55:24];

   // rounding divide by 2^shift, ties away from zero
   assign mask     = (32'h1 << cfg.shift) - 32'h1;
   assign low_bits = q & mask;
   assign rem      = $signed({1'b0, low_bits}) - $signed({32'b0, q[31]});
   assign thr      = $signed({1'b0, (mask >> 1)});
   assign round_up = rem > thr;
   assign q_shr    = q >>> cfg.shift;
   assign sh       = $signed({q_shr[31], q_shr}) + $signed({32'b0, round_up});

   always_comb begin
      if (sh < -33'sd32768) begin
         sat16 = -17'sd32768;
      end else if (sh > 33'sd32767) begin
         sat16 = 17'sd32767;
      end else begin
         sat16 = sh[16:0];
      end
   end

   // the int16 saturation after the add never bites before the 0..255 clip
   assign with_zp = $signed({sat16[16], sat16}) + $signed({10'b0, cfg.offset});

   always_comb begin
      if (with_zp[17]) begin
         u8 = 8'd0;
      end else if (with_zp > 18'sd255) begin
         u8 = 8'd255;
      end else begin
         u8 = with_zp[7:0];
      end
   end

   // upper bound first, so crossed bounds give clamp_low
   assign upper_clamped = (u8 > cfg.clamp_high) ? cfg.clamp_high : u8;
   assign quantized     = (upper_clamped < cfg.clamp_low) ? cfg.clamp_low : upper_clamped;

endmodule

>>> hdl/q31_requantize_int32_to_uint8_top.sv
// requantizes a stream of signed 32-bit accumulators to unsigned 8-bit values:
// q31 multiply by the scale mantissa, rounding right shift (ties away from zero),
// int16 saturation, zero point add, 0..255 clip and clamp to clamp_low..clamp_high.
// a word is taken every cycle while req_ready is high; each word passes through the
// input register and then the result register, with the multiply and rounding
// between them. req_ready drops only when both registers hold words and the result
// side stalls. the scale register is decoded into multiplier and shift when written;
// write the csr registers only while no word is in flight. last_in rides along to last_out.
module q31_requantize_int32_to_uint8_top (
   input  logic                             clock,
   input  logic                             reset,
   // input words
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rqz_pkg::req_payload_type         req_data,
   // result words
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rqz_pkg::rsp_payload_type         rsp_data,
   // configuration writes
   input  logic                             csr_write_en,
   input  logic [rqz_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rqz_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rqz_pkg::*;

   cfg_type          cfg;

   // input register
   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_payload_type  s1_data_ff;

   // result register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_data_ff;
   rsp_payload_type  rsp_data_in;

   logic             out_free;
   logic             s1_move;
   logic             req_take;
   logic [7:0]       quantized;

   rqz_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rqz_datapath u_datapath (
      .cfg         (cfg),
      .accumulator (s1_data_ff.accumulator),
      .quantized   (quantized)
   );

   // result register frees up when empty or when its word is taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   assign rsp_data_in.quantized = quantized;
   assign rsp_data_in.last_out  = s1_data_ff.last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a full pipe with a stalled result side takes nothing new
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while both registers full and result stalled");

   // a held word in the input register is not dropped
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("input register lost a waiting word");

   // a loaded result respects the lower clamp bound
   a_low_bound: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_data_ff.quantized >= $past(cfg.clamp_low)))
      else $error("result below clamp_low");

   // the last flag follows its word into the result register
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_data_ff.last_out == $past(s1_data_ff.last_in)))
      else $error("last flag not carried with its word");

endmodule

>>> test/requant_result_checker.sv
module requant_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  rqz_pkg::req_payload_type          req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  rqz_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_write_en,
   input  logic [rqz_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rqz_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                error_count,
   output int                                pending_count
);
   import rqz_pkg::*;

   // shadow copy of the csr registers
   logic [29:0] scale_reg;
   logic [7:0]  offset_reg;
   logic [7:0]  clamp_low_reg;
   logic [7:0]  clamp_high_reg;

   rsp_payload_type expected_bytes[$];
   rsp_payload_type oldest;
   int              mismatches = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] requantize_word(logic signed [31:0] acc);
      longint      mult, prod, q, rem, thr, sh, v;
      int          shift;
      logic [63:0] sum;
      logic [31:0] qu, mask;
      logic signed [31:0] qs;
      mult  = longint'({1'b1, scale_reg[22:0]}) << 7;
      shift = 126 - int'(scale_reg[29:23]);
      if (shift < 0) shift = 0;
      if (shift > 31) shift = 31;
      // q31 product, round half up, keep bits 62..31
      prod = longint'(acc) * mult;
      sum  = prod + 64'h0000_0000_4000_0000;
      qu   = sum[62:31];
      qs   = qu;
      q    = qs;
      // rounding shift, ties away from zero
      mask = (32'd1 << shift) - 32'd1;
      rem  = longint'(qu & mask) - (q < 0 ? 1 : 0);
      thr  = longint'(mask >> 1);
      sh   = q >>> shift;
      if (rem > thr) sh = sh + 1;
      v = clip(sh, -32768, 32767);
      v = clip(v + longint'(offset_reg), -32768, 32767);
      v = clip(v, 0, 255);
      if (v > longint'(clamp_high_reg)) v = longint'(clamp_high_reg);
      if (v < longint'(clamp_low_reg)) v = longint'(clamp_low_reg);
      return v[7:0];
   endfunction

   task automatic note_failure(input string what, input int want_v, input int got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("checker: %s mismatch at %0t, expected %0d, got %0d",
                  what, $realtime, want_v, got_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scale_reg      = 30'h3F00_0000;
         offset_reg     = 8'd0;
         clamp_low_reg  = 8'd0;
         clamp_high_reg = 8'd255;
         expected_bytes.delete();
      end else begin
         if (req_valid && req_ready)
            expected_bytes.push_back('{quantized: requantize_word(req_data.accumulator),
                                       last_out: req_data.last_in});
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               note_failure("unexpected word", -1, int'(rsp_data.quantized));
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_data.quantized !== oldest.quantized)
                  note_failure("quantized", int'(oldest.quantized), int'(rsp_data.quantized));
               if (rsp_data.last_out !== oldest.last_out)
                  note_failure("last_out", int'(oldest.last_out), int'(rsp_data.last_out));
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_SCALE:      scale_reg      = csr_wdata[29:0];
               CSR_OFFSET:     offset_reg     = csr_wdata[7:0];
               CSR_CLAMP_LOW:  clamp_low_reg  = csr_wdata[7:0];
               CSR_CLAMP_HIGH: clamp_high_reg = csr_wdata[7:0];
            endcase
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_bytes.size();
   end

endmodule

>>> test/tb_q31_requantize_int32_to_uint8_top.sv
module tb_q31_requantize_int32_to_uint8_top;
   import rqz_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   rsp_payload_type        rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int  error_count;
   int  pending_count;
   // cleared for one whole phase so that both sides run back to back
   logic idling_on = 1'b1;
   int  words_sent = 0;
   int  settings_loaded = 0;

   // 10 time unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   q31_requantize_int32_to_uint8_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   requant_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // result side back-pressure: while idling_on is set, rsp_ready drops at random, one chance in ten
   always @(posedge clock)
      rsp_ready <= !(idling_on && $urandom_range(0, 99) < 10);

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // offer one word and hold it until the block takes it; an optional gap goes first
   task automatic send_word(input logic signed [31:0] acc, input logic last);
      if (idling_on && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_valid <= 1'b1;
      req_data  <= '{accumulator: acc, last_in: last};
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [29:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   // drain the pipe, let the two register stages settle, then write all four registers
   task automatic load_settings(input logic [29:0] scale, input logic [7:0] zp,
                                input logic [7:0] lo, input logic [7:0] hi);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      write_reg(CSR_SCALE, scale);
      write_reg(CSR_OFFSET, {22'd0, zp});
      write_reg(CSR_CLAMP_LOW,  {22'd0, lo});
      write_reg(CSR_CLAMP_HIGH, {22'd0, hi});
      csr_write_en <= 1'b0;
      settings_loaded++;
   endtask

   // mostly useful scales (shift in the working range), some raw patterns and edges
   function automatic logic [29:0] random_scale();
      case ($urandom_range(0, 7))
         0: return 30'($urandom);
         1: begin
            case ($urandom_range(0, 5))
               0: return 30'h3F00_0000;
               1: return 30'h3F7F_FFFF;
               2: return 30'h2F80_0000;
               3: return 30'h3F80_0000;
               4: return 30'h0000_0000;
               default: return 30'h3FFF_FFFF;
            endcase
         end
         default: return {7'($urandom_range(100, 126)), 23'($urandom)};
      endcase
   endfunction

   // spread magnitudes over all powers of two so every shift sees live values
   function automatic logic signed [31:0] random_accumulator();
      logic [31:0] mag;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: begin
            mag = $urandom >> $urandom_range(0, 31);
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   initial begin
      logic [29:0] scale;
      logic [7:0]  zp, lo, hi, tmp;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_SCALE;
      csr_wdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings (scale 0.5): accumulator extremes and results at the top of the 0..255 clip
      send_word(32'sh8000_0000, 1'b0);
      send_word(32'sh7FFF_FFFF, 1'b1);
      send_word(32'sd0, 1'b0);
      send_word(-32'sd1, 1'b1);
      send_word(32'sd1, 1'b0);
      send_word(32'sd510, 1'b0);
      send_word(32'sd511, 1'b1);

      // scale one quarter, zero point mid-range: exact ties both signs
      load_settings(30'h3E80_0000, 8'd128, 8'd0, 8'd255);
      send_word(32'sd2, 1'b0);
      send_word(32'sd6, 1'b1);
      send_word(-32'sd2, 1'b0);
      send_word(-32'sd6, 1'b0);
      send_word(-32'sd10, 1'b1);

      // scale just below one: exponent 127 pins the shift at zero, largest multiplier
      load_settings(30'h3FFF_FFFF, 8'd100, 8'd0, 8'd255);
      send_word(32'sd3, 1'b0);
      send_word(-32'sd3, 1'b1);
      send_word(32'sh7FFF_FFFF, 1'b0);

      // tiny scale: shift pinned at 31
      load_settings(30'h0000_0000, 8'd255, 8'd0, 8'd255);
      send_word(32'sh8000_0000, 1'b1);
      send_word(32'sh7FFF_FFFF, 1'b0);
      send_word(32'sd12345, 1'b1);

      // crossed clamp bounds, output should stick at clamp_low
      load_settings(30'h3F7F_FFFF, 8'd7, 8'd200, 8'd50);
      send_word(32'sd0, 1'b0);
      send_word(32'sd1000, 1'b1);
      send_word(-32'sd1000, 1'b0);

      // narrow clamp window
      load_settings(30'h3F00_0000, 8'd255, 8'd10, 8'd20);
      send_word(-32'sd500, 1'b0);
      send_word(32'sd30, 1'b1);
      send_word(32'sh8000_0000, 1'b0);

      // random settings per phase, random words inside
      for (int phase = 0; phase < 12; phase++) begin
         scale = random_scale();
         case ($urandom_range(0, 3))
            0: zp = 8'd0;
            1: zp = 8'd255;
            default: zp = 8'($urandom);
         endcase
         lo = 8'($urandom);
         hi = 8'($urandom);
         case ($urandom_range(0, 4))
            0, 1: begin
               lo = 8'd0;
               hi = 8'd255;
            end
            2: begin
               if (lo > hi) begin
                  tmp = lo;
                  lo  = hi;
                  hi  = tmp;
               end
            end
            3: begin
               lo = 8'd255;
               hi = 8'd0;
            end
            default: ;
         endcase
         load_settings(scale, zp, lo, hi);
         idling_on <= (phase != 4);
         for (int n = 0; n < 120; n++)
            send_word(random_accumulator(), 1'($urandom));
      end

      // wait for the last results and for anything stray after them
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);

      $display("run: %0d words requantized under %0d register settings", words_sent,
               settings_loaded + 1);
      $display("run: ties, scale shift limits, int16 saturation and crossed clamps exercised");
      if (error_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
